// ===== sv/oriented_gradient_integral_image_assert.svh =====
// Assertion macros used by the checker file of the oriented gradient integral image.
`ifndef ORIENTED_GRADIENT_INTEGRAL_IMAGE_ASSERT_SVH
`define ORIENTED_GRADIENT_INTEGRAL_IMAGE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define OGGI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oggi assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define OGGI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oggi assertion failed");

`endif

// ===== sv/oggi_pkg.sv =====
// Package with the types and constants of the oriented gradient integral image.
`default_nettype none
package oggi_pkg;

  localparam int IMG_WIDTH  = 640;
  localparam int IMG_HEIGHT = 480;
  localparam int COL_W      = $clog2(IMG_WIDTH);
  localparam int ROW_W      = $clog2(IMG_HEIGHT + 1);
  localparam int NUM_TAPS   = 4;
  localparam int NUM_CH     = 8;
  localparam int SUM_W      = 48;
  localparam int COEF_W     = 16;
  localparam int GRAD_W     = 9;
  localparam int PROD_W     = COEF_W + GRAD_W;
  localparam int RESP_W     = PROD_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1) + 1;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [8:0] out_row_t;
  typedef logic [9:0] out_col_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RESP_W-1:0] resp_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  localparam col_t LAST_COL = col_t'(IMG_WIDTH - 1);
  localparam row_t LAST_ROW = row_t'(IMG_HEIGHT - 1);
  localparam row_t ALL_ROWS = row_t'(IMG_HEIGHT);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_KX_H  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KX_V  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KX_DM = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KX_DA = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KY_H  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KY_V  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KY_DM = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KY_DA = 4'd7;

  localparam coef_t COEF_ONE = 16'sd16384;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel;
    logic       frame_start;
  } req_t;

  typedef struct packed {
    out_row_t out_row;
    out_col_t out_col;
    sum_t     sum_dx_neg_dy;
    sum_t     sum_dx_pos_dy;
    sum_t     sum_absdx_neg_dy;
    sum_t     sum_absdx_pos_dy;
    sum_t     sum_dy_neg_dx;
    sum_t     sum_dy_pos_dx;
    sum_t     sum_absdy_neg_dx;
    sum_t     sum_absdy_pos_dx;
    logic     run_last;
    logic     frame_done;
  } rsp_t;

  typedef struct packed {
    coef_t [NUM_TAPS-1:0] kx;
    coef_t [NUM_TAPS-1:0] ky;
  } kernel_t;

  // The first response starts as the horizontal difference, the second as the vertical one.
  localparam kernel_t KERN_RESET = '{
    kx: {coef_t'(0), coef_t'(0), coef_t'(0), COEF_ONE},
    ky: {coef_t'(0), coef_t'(0), COEF_ONE, coef_t'(0)}
  };

  // One column step handed from the front to the back.
  typedef struct packed {
    logic       fill;
    logic       active;
    logic       final_col;
    logic       frame_final;
    logic [7:0] a;
    logic [7:0] m;
    logic [7:0] b;
    row_t       out_row;
    col_t       col;
  } op_t;

endpackage
`default_nettype wire

// ===== sv/oggi_front.sv =====
// Front end: request intake, frame counters, line buffers and column step records.
`default_nettype none
module oggi_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire oggi_pkg::req_t req,
  input  wire oggi_pkg::qcnt_t q_count,
  output logic                push,
  output oggi_pkg::op_t       op
);

  logic [7:0] rm1 [oggi_pkg::IMG_WIDTH];
  logic [7:0] rm2 [oggi_pkg::IMG_WIDTH];

  oggi_pkg::row_t row;
  oggi_pkg::col_t pcol;
  oggi_pkg::col_t fcol;

  logic           s1_valid;
  logic           s1_pix;
  oggi_pkg::row_t s1_row;
  oggi_pkg::col_t s1_col;
  logic [7:0]     s1_pixel;
  logic           s1_byp;
  logic [7:0]     s1_bm1;
  logic [7:0]     s1_bm2;
  logic [7:0]     rd1;
  logic [7:0]     rd2;

  logic           is_pix;
  logic           fs;
  logic           take;
  logic           accept;
  oggi_pkg::row_t cur_row;
  oggi_pkg::col_t cur_col;
  oggi_pkg::col_t rd_addr;
  logic [7:0]     s1_m;
  logic [7:0]     s1_m2;

  always_comb begin
    is_pix  = (req.req_type == oggi_pkg::REQ_PIXEL);
    fs      = is_pix && req.frame_start;
    cur_row = fs ? '0 : row;
    cur_col = fs ? '0 : pcol;
    take    = is_pix ? (fs || (row < oggi_pkg::ALL_ROWS)) : (row == oggi_pkg::ALL_ROWS);
    rd_addr = is_pix ? cur_col : fcol;
    req_stall = (oggi_pkg::qcnt_t'(q_count + oggi_pkg::qcnt_t'(s1_valid))
                 >= oggi_pkg::qcnt_t'(oggi_pkg::QDEPTH));
    accept  = req_valid && !req_stall && take;
    s1_m    = s1_byp ? s1_bm1 : rd1;
    s1_m2   = s1_byp ? s1_bm2 : rd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      pcol     <= '0;
      fcol     <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (is_pix) begin
          fcol <= fs ? '0 : fcol;
          if (cur_col == oggi_pkg::LAST_COL) begin
            pcol <= '0;
            row  <= oggi_pkg::row_t'(cur_row + 1'b1);
          end else begin
            pcol <= oggi_pkg::col_t'(cur_col + 1'b1);
            row  <= cur_row;
          end
        end else if (fcol == oggi_pkg::LAST_COL) begin
          fcol <= '0;
          pcol <= '0;
          row  <= '0;
        end else begin
          fcol <= oggi_pkg::col_t'(fcol + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd1      <= rm1[rd_addr];
      rd2      <= rm2[rd_addr];
      s1_pix   <= is_pix;
      s1_row   <= is_pix ? cur_row : oggi_pkg::ALL_ROWS;
      s1_col   <= rd_addr;
      s1_pixel <= req.pixel;
      s1_byp   <= s1_valid && s1_pix && (s1_col == rd_addr);
      s1_bm1   <= s1_pixel;
      s1_bm2   <= s1_m;
    end
    if (s1_valid && s1_pix) begin
      rm1[s1_col] <= s1_pixel;
      rm2[s1_col] <= s1_m;
    end
  end

  always_comb begin
    push           = s1_valid;
    op.fill        = (s1_col == '0);
    op.final_col   = (s1_col == oggi_pkg::LAST_COL);
    op.col         = s1_col;
    op.m           = s1_m;
    if (s1_pix) begin
      op.active      = (s1_row != '0);
      op.frame_final = 1'b0;
      op.a           = (s1_row >= oggi_pkg::row_t'(2)) ? s1_m2 : s1_m;
      op.b           = s1_pixel;
      op.out_row     = oggi_pkg::row_t'(s1_row - 1'b1);
    end else begin
      op.active      = 1'b1;
      op.frame_final = 1'b1;
      op.a           = s1_m2;
      op.b           = s1_m;
      op.out_row     = oggi_pkg::LAST_ROW;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oggi_queue.sv =====
// Short queue of column step records between the front and the back.
`default_nettype none
module oggi_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire oggi_pkg::op_t   push_op,
  input  wire logic            pop,
  output oggi_pkg::op_t        pop_op,
  output logic                 empty,
  output oggi_pkg::qcnt_t      count
);

  oggi_pkg::op_t                  slots [oggi_pkg::QDEPTH];
  logic [oggi_pkg::QPTR_W-1:0]    wr_ptr;
  logic [oggi_pkg::QPTR_W-1:0]    rd_ptr;

  assign empty  = (count == '0);
  assign pop_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= oggi_pkg::qcnt_t'(count + 1'b1);
        2'b01:   count <= oggi_pkg::qcnt_t'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oggi_back.sv =====
// Back end: pixel window, oriented responses, channel row sums and the integral row memory.
`default_nettype none
module oggi_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire oggi_pkg::kernel_t kern,
  input  wire oggi_pkg::op_t     op,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output oggi_pkg::rsp_t         rsp
);

  localparam int MEM_W = oggi_pkg::NUM_CH * oggi_pkg::SUM_W;

  logic en;

  logic [7:0] wa [3];
  logic [7:0] wc [3];
  logic [7:0] wb [3];
  logic [7:0] na [3];
  logic [7:0] nc [3];
  logic [7:0] nb [3];
  logic       second;
  logic       sec_final;
  oggi_pkg::row_t sec_row;
  logic       upd;
  logic       emit_now;

  logic           a_valid;
  oggi_pkg::grad_t a_g [oggi_pkg::NUM_TAPS];
  oggi_pkg::row_t a_row;
  oggi_pkg::col_t a_col;
  logic           a_last;
  logic           a_done;

  logic           b_valid;
  oggi_pkg::prod_t b_px [oggi_pkg::NUM_TAPS];
  oggi_pkg::prod_t b_py [oggi_pkg::NUM_TAPS];
  oggi_pkg::row_t b_row;
  oggi_pkg::col_t b_col;
  logic           b_last;
  logic           b_done;

  logic           c_valid;
  oggi_pkg::resp_t c_dx;
  oggi_pkg::resp_t c_dy;
  oggi_pkg::row_t c_row;
  oggi_pkg::col_t c_col;
  logic           c_last;
  logic           c_done;

  logic           d_valid;
  oggi_pkg::sum_t rs [oggi_pkg::NUM_CH];
  oggi_pkg::row_t d_row;
  oggi_pkg::col_t d_col;
  logic           d_last;
  logic           d_done;
  logic [MEM_W-1:0] above;

  logic [MEM_W-1:0] integ [oggi_pkg::IMG_WIDTH];

  oggi_pkg::grad_t g_next [oggi_pkg::NUM_TAPS];
  oggi_pkg::resp_t dx_sum;
  oggi_pkg::resp_t dy_sum;
  oggi_pkg::resp_t abs_dx;
  oggi_pkg::resp_t abs_dy;
  oggi_pkg::sum_t  add [oggi_pkg::NUM_CH];
  oggi_pkg::sum_t  rs_next [oggi_pkg::NUM_CH];
  oggi_pkg::sum_t  v [oggi_pkg::NUM_CH];
  logic [MEM_W-1:0] v_word;

  function automatic oggi_pkg::grad_t diff(input logic [7:0] x, input logic [7:0] y);
    diff = $signed({1'b0, x}) - $signed({1'b0, y});
  endfunction

  assign en  = !rsp_valid || !rsp_stall;
  assign pop = en && !second && !empty;
  assign upd = en && (second || !empty);

  always_comb begin
    if (second) begin
      na[0] = wa[1]; na[1] = wa[2]; na[2] = wa[2];
      nc[0] = wc[1]; nc[1] = wc[2]; nc[2] = wc[2];
      nb[0] = wb[1]; nb[1] = wb[2]; nb[2] = wb[2];
      emit_now = 1'b1;
    end else if (op.fill) begin
      for (int i = 0; i < 3; i++) begin
        na[i] = op.a;
        nc[i] = op.m;
        nb[i] = op.b;
      end
      emit_now = !empty && op.active && (op.col != '0);
    end else begin
      na[0] = wa[1]; na[1] = wa[2]; na[2] = op.a;
      nc[0] = wc[1]; nc[1] = wc[2]; nc[2] = op.m;
      nb[0] = wb[1]; nb[1] = wb[2]; nb[2] = op.b;
      emit_now = !empty && op.active && (op.col != '0);
    end
    g_next[0] = diff(nc[2], nc[0]);
    g_next[1] = diff(nb[1], na[1]);
    g_next[2] = diff(nb[2], na[0]);
    g_next[3] = diff(nb[0], na[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second  <= 1'b0;
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= upd && emit_now;
      if (second) begin
        second <= 1'b0;
      end else if (pop && op.active && op.final_col) begin
        second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      for (int i = 0; i < 3; i++) begin
        wa[i] <= na[i];
        wc[i] <= nc[i];
        wb[i] <= nb[i];
      end
      for (int i = 0; i < oggi_pkg::NUM_TAPS; i++) begin
        a_g[i] <= g_next[i];
      end
      if (second) begin
        a_row  <= sec_row;
        a_col  <= oggi_pkg::LAST_COL;
        a_last <= 1'b1;
        a_done <= sec_final;
      end else begin
        a_row     <= op.out_row;
        a_col     <= oggi_pkg::col_t'(op.col - 1'b1);
        a_last    <= !op.final_col;
        a_done    <= 1'b0;
        sec_row   <= op.out_row;
        sec_final <= op.frame_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < oggi_pkg::NUM_TAPS; i++) begin
        b_px[i] <= $signed(kern.kx[i]) * a_g[i];
        b_py[i] <= $signed(kern.ky[i]) * a_g[i];
      end
      b_row  <= a_row;
      b_col  <= a_col;
      b_last <= a_last;
      b_done <= a_done;
    end
  end

  always_comb begin
    dx_sum = '0;
    dy_sum = '0;
    for (int i = 0; i < oggi_pkg::NUM_TAPS; i++) begin
      dx_sum = oggi_pkg::resp_t'(dx_sum + oggi_pkg::resp_t'(b_px[i]));
      dy_sum = oggi_pkg::resp_t'(dy_sum + oggi_pkg::resp_t'(b_py[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_dx   <= dx_sum;
      c_dy   <= dy_sum;
      c_row  <= b_row;
      c_col  <= b_col;
      c_last <= b_last;
      c_done <= b_done;
    end
  end

  always_comb begin
    abs_dx = (c_dx > 0) ? c_dx : oggi_pkg::resp_t'(-c_dx);
    abs_dy = (c_dy > 0) ? c_dy : oggi_pkg::resp_t'(-c_dy);
    for (int i = 0; i < oggi_pkg::NUM_CH; i++) begin
      add[i] = '0;
    end
    if (c_dy > 0) begin
      add[1] = oggi_pkg::sum_t'(c_dx);
      add[3] = oggi_pkg::sum_t'(abs_dx);
    end else begin
      add[0] = oggi_pkg::sum_t'(c_dx);
      add[2] = oggi_pkg::sum_t'(abs_dx);
    end
    if (c_dx > 0) begin
      add[5] = oggi_pkg::sum_t'(c_dy);
      add[7] = oggi_pkg::sum_t'(abs_dy);
    end else begin
      add[4] = oggi_pkg::sum_t'(c_dy);
      add[6] = oggi_pkg::sum_t'(abs_dy);
    end
    for (int i = 0; i < oggi_pkg::NUM_CH; i++) begin
      rs_next[i] = oggi_pkg::sum_t'(((c_col == '0) ? '0 : rs[i]) + add[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid) begin
      for (int i = 0; i < oggi_pkg::NUM_CH; i++) begin
        rs[i] <= rs_next[i];
      end
      above  <= integ[c_col];
      d_row  <= c_row;
      d_col  <= c_col;
      d_last <= c_last;
      d_done <= c_done;
    end
  end

  always_comb begin
    for (int i = 0; i < oggi_pkg::NUM_CH; i++) begin
      v[i] = oggi_pkg::sum_t'(((d_row == '0) ? '0 : $signed(above[i*oggi_pkg::SUM_W +:
             oggi_pkg::SUM_W])) + rs[i]);
      v_word[i*oggi_pkg::SUM_W +: oggi_pkg::SUM_W] = v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en && d_valid) begin
      integ[d_col] <= v_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && d_valid) begin
      rsp.out_row          <= oggi_pkg::out_row_t'(d_row);
      rsp.out_col          <= oggi_pkg::out_col_t'(d_col);
      rsp.sum_dx_neg_dy    <= v[0];
      rsp.sum_dx_pos_dy    <= v[1];
      rsp.sum_absdx_neg_dy <= v[2];
      rsp.sum_absdx_pos_dy <= v[3];
      rsp.sum_dy_neg_dx    <= v[4];
      rsp.sum_dy_pos_dx    <= v[5];
      rsp.sum_absdy_neg_dx <= v[6];
      rsp.sum_absdy_pos_dx <= v[7];
      rsp.run_last         <= d_last;
      rsp.frame_done       <= d_done;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oriented_gradient_integral_image.sv =====
// Top level of the oriented gradient integral image: kernel registers and block wiring.
//
// Requests arrive on req with req_valid/req_stall, one gray pixel in raster order or one
// flush item; a request is taken at a clock edge with req_valid high and req_stall low.
// Results leave on rsp with rsp_valid/rsp_stall in the same way. The eight signed and
// absolute gradient channels are integrated over the image and emitted one row late; each
// pixel at row r >= 1, column c >= 1 gives entry (r-1, c-1), the last column of a row also
// gives (r-1, last column), and a row of flush items drains the bottom row of the frame.
// Throughput is one request per cycle while the queue has room. The last column of each
// active row takes a second back end step in which no record is popped; the four-entry
// queue absorbs these steps for the first rows of an unbroken stream, after which req_stall
// rises in every row. Without stalls a request passes the front end line buffer read, the
// queue, and the window, multiply, add, row sum and output stages before its first result.
// The kernel registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, as the block itself does not enforce it. Synchronous reset
// loads the default kernels, empties the queue and pipeline and restarts the frame
// counters; the line buffers and integral row need no clearing pass. When rsp_stall is
// high with rsp_valid the back end holds; the queue fills and req_stall then rises.
`default_nettype none
module oriented_gradient_integral_image (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire oggi_pkg::req_t                  req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output oggi_pkg::rsp_t                       rsp,
  input  wire logic                            cfg_we,
  input  wire logic [oggi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire oggi_pkg::coef_t                 cfg_data
);

  oggi_pkg::kernel_t kern;
  oggi_pkg::op_t     push_op;
  oggi_pkg::op_t     pop_op;
  oggi_pkg::qcnt_t   q_count;
  logic              push;
  logic              pop;
  logic              empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      kern <= oggi_pkg::KERN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        oggi_pkg::CFG_KX_H:  kern.kx[0] <= cfg_data;
        oggi_pkg::CFG_KX_V:  kern.kx[1] <= cfg_data;
        oggi_pkg::CFG_KX_DM: kern.kx[2] <= cfg_data;
        oggi_pkg::CFG_KX_DA: kern.kx[3] <= cfg_data;
        oggi_pkg::CFG_KY_H:  kern.ky[0] <= cfg_data;
        oggi_pkg::CFG_KY_V:  kern.ky[1] <= cfg_data;
        oggi_pkg::CFG_KY_DM: kern.ky[2] <= cfg_data;
        oggi_pkg::CFG_KY_DA: kern.ky[3] <= cfg_data;
        default:             kern       <= kern;
      endcase
    end
  end

  oggi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_count   (q_count),
    .push      (push),
    .op        (push_op)
  );

  oggi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty),
    .count   (q_count)
  );

  oggi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .kern      (kern),
    .op        (pop_op),
    .empty     (empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== sv/oggi_checker.sv =====
// Port-level checker of the oriented gradient integral image and its bind statement.
`default_nettype none
`include "oriented_gradient_integral_image_assert.svh"
module oggi_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire oggi_pkg::rsp_t rsp
);

  localparam oggi_pkg::out_col_t LAST_OUT_COL = oggi_pkg::out_col_t'(oggi_pkg::IMG_WIDTH - 1);
  localparam oggi_pkg::out_col_t PREV_OUT_COL = oggi_pkg::out_col_t'(oggi_pkg::IMG_WIDTH - 2);
  localparam oggi_pkg::out_row_t LAST_OUT_ROW = oggi_pkg::out_row_t'(oggi_pkg::IMG_HEIGHT - 1);

  `OGGI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `OGGI_ASSERT_NOW(a_frame_done_pos, rsp_valid && rsp.frame_done,
                   rsp.run_last && rsp.out_col == LAST_OUT_COL && rsp.out_row == LAST_OUT_ROW)
  `OGGI_ASSERT_NOW(a_pair_first, rsp_valid && !rsp.run_last, rsp.out_col == PREV_OUT_COL)
  `OGGI_ASSERT_NEXT(a_pair_second, rsp_valid && !rsp_stall && !rsp.run_last,
                    !rsp_valid || (rsp.out_col == LAST_OUT_COL && rsp.run_last))

endmodule

bind oriented_gradient_integral_image oggi_checker u_oggi_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
